// File: hdl/deq_pkg.sv
`default_nettype none

package deq_pkg;

    // Fixed field widths of the item and result beats
    localparam int OPCODE_W = 3;
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam opcode_t OP_PUSH_TAIL  = 3'd0;
    localparam opcode_t OP_PUSH_FRONT = 3'd1;
    localparam opcode_t OP_POP_TAIL   = 3'd2;
    localparam opcode_t OP_POP_FRONT  = 3'd3;
    localparam opcode_t OP_READ       = 3'd4;
    localparam opcode_t OP_SWAP       = 3'd5;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

endpackage

`default_nettype wire

// File: hdl/deq_store.sv
`default_nettype none

// Element store: one write port, two read ports, registered read data.
module deq_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] q_a,
    output logic      [WIDTH-1:0] q_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            q_a <= mem[raddr_a];
            q_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// File: hdl/double_ended_queue.sv
`default_nettype none

// Bounded double-ended queue over a circular element store.
// Input channel (in_valid/in_ready) carries one operation per beat: push back,
// push front, pop back, pop front, read at a logical index from the front, or
// swap two logical indices. Output channel (out_valid/out_ready) returns one
// beat per operation: read_data, status and the element count after it.
// Results pass the result stage and the output register; a successful pop or
// read first passes the store read register. Pushes and refused operations go
// back to back while the receiver keeps up; pops and reads hold input off in
// the fetch state, swaps in both swap states (the two reads share one access,
// then the two write-backs use the single write port one at a time).
// Unused opcodes six and seven change nothing and report ok.
// A one-entry result stage sits ahead of the output register, so one item is
// taken while a result waits; further items stall while the receiver stalls.
// Reset empties the queue (count and front position cleared); store contents
// stay as they are and are never read before they are written.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH         = 1024,
    parameter int ELEMENT_WIDTH = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [OPCODE_W-1:0] opcode,
    input  wire logic [DATA_W-1:0]   data,
    input  wire logic [INDEX_W-1:0]  index_a,
    input  wire logic [INDEX_W-1:0]  index_b,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [DATA_W-1:0]        read_data,
    output logic [STATUS_W-1:0]      status,
    output logic [COUNT_W-1:0]       count
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int SW    = CMP_W + 1;
    localparam int XW    = (ELEMENT_WIDTH > DATA_W) ? ELEMENT_WIDTH : DATA_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_FETCH  = 2'd1;
    localparam logic [1:0] S_SWAP_A = 2'd2;
    localparam logic [1:0] S_SWAP_B = 2'd3;

    // Physical slot of a logical position; base + logical stays below 2*DEPTH
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [SW-1:0] logical);
        logic [SW-1:0] sum;
        sum = SW'(base) + logical;
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Control state
    logic [1:0]       state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             out_valid_reg, out_valid_next;

    // Payload
    logic [DATA_W-1:0]   pend_data_reg, out_data_reg;
    logic [STATUS_W-1:0] pend_status_reg, out_status_reg;
    logic [COUNT_W-1:0]  pend_count_reg, out_count_reg;
    logic [AW-1:0]       sa_reg, sb_reg;

    // Store ports
    logic                     mem_we, mem_re;
    logic [AW-1:0]            mem_waddr, mem_raddr_a, mem_raddr_b;
    logic [ELEMENT_WIDTH-1:0] mem_wdata, mem_q_a, mem_q_b;

    // Decode of the item at the input
    logic                     acc, out_free;
    logic                     is_full, is_empty, a_bad, b_bad;
    logic [XW-1:0]            data_wide, rd_wide;
    logic [ELEMENT_WIDTH-1:0] push_value;
    logic [STATUS_W-1:0]      dec_status;
    logic [AW-1:0]            dec_head, dec_waddr, dec_raddr_a, dec_raddr_b;
    logic [CNT_W-1:0]         dec_count;
    logic                     dec_we, dec_fetch, dec_swap;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && (!pend_valid_reg || out_free);
    assign acc      = in_valid && in_ready;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign a_bad    = (CMP_W'(index_a) >= CMP_W'(count_reg));
    assign b_bad    = (CMP_W'(index_b) >= CMP_W'(count_reg));

    // Drop data bits above the element width
    assign data_wide  = XW'(data);
    assign push_value = data_wide[ELEMENT_WIDTH-1:0];
    assign rd_wide    = XW'(mem_q_a);

    always_comb
    begin
        dec_status  = ST_OK;
        dec_head    = head_reg;
        dec_count   = count_reg;
        dec_we      = 1'b0;
        dec_waddr   = slot_of(head_reg, SW'(count_reg));
        dec_raddr_a = slot_of(head_reg, SW'(index_a));
        dec_raddr_b = slot_of(head_reg, SW'(index_b));
        dec_fetch   = 1'b0;
        dec_swap    = 1'b0;
        case (opcode)
            OP_PUSH_TAIL:
            begin
                if (is_full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_we    = 1'b1;
                    dec_count = count_reg + CNT_W'(1);
                end
            end
            OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_head  = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
                    dec_waddr = dec_head;
                    dec_we    = 1'b1;
                    dec_count = count_reg + CNT_W'(1);
                end
            end
            OP_POP_TAIL:
            begin
                if (is_empty)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_raddr_a = slot_of(head_reg, SW'(count_reg - CNT_W'(1)));
                    dec_fetch   = 1'b1;
                    dec_count   = count_reg - CNT_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_raddr_a = head_reg;
                    dec_head    = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
                    dec_fetch   = 1'b1;
                    dec_count   = count_reg - CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (a_bad)
                begin
                    dec_status = ST_RANGE;
                end
                else
                begin
                    dec_fetch = 1'b1;
                end
            end
            OP_SWAP:
            begin
                if (a_bad || b_bad)
                begin
                    dec_status = ST_RANGE;
                end
                else
                begin
                    dec_swap = 1'b1;
                end
            end
            default:
            begin
                dec_status = ST_OK;
            end
        endcase
    end

    // Store access: pushes write at acceptance; a swap writes back in the two
    // swap states that follow. Reads are only issued from idle, so a read never
    // meets a write to the same entry in flight.
    always_comb
    begin
        mem_we    = acc && dec_we;
        mem_waddr = dec_waddr;
        mem_wdata = push_value;
        case (state_reg)
            S_SWAP_A:
            begin
                mem_we    = 1'b1;
                mem_waddr = sa_reg;
                mem_wdata = mem_q_b;
            end
            S_SWAP_B:
            begin
                mem_we    = 1'b1;
                mem_waddr = sb_reg;
                mem_wdata = mem_q_a;
            end
            default:
            begin
                mem_we = acc && dec_we;
            end
        endcase
    end

    assign mem_re      = acc && (dec_fetch || dec_swap);
    assign mem_raddr_a = dec_raddr_a;
    assign mem_raddr_b = dec_raddr_b;

    deq_store #(
        .DEPTH (DEPTH),
        .WIDTH (ELEMENT_WIDTH)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .q_a     (mem_q_a),
        .q_b     (mem_q_b)
    );

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        // Drop the output beat once taken, then advance the pending result
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_valid_reg && out_free)
        begin
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    head_next  = dec_head;
                    count_next = dec_count;
                    if (dec_fetch)
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        // Swap reports before its write-back completes
                        pend_valid_next = 1'b1;
                        if (dec_swap)
                        begin
                            state_next = S_SWAP_A;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                pend_valid_next = 1'b1;
                state_next      = S_IDLE;
            end
            S_SWAP_A:
            begin
                state_next = S_SWAP_B;
            end
            S_SWAP_B:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_valid_reg && out_free)
        begin
            out_data_reg   <= pend_data_reg;
            out_status_reg <= pend_status_reg;
            out_count_reg  <= pend_count_reg;
        end
        if (acc)
        begin
            pend_data_reg   <= '0;
            pend_status_reg <= dec_status;
            pend_count_reg  <= COUNT_W'(dec_count);
            sa_reg          <= dec_raddr_a;
            sb_reg          <= dec_raddr_b;
        end
        if (state_reg == S_FETCH)
        begin
            pend_data_reg <= rd_wide[DATA_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;
    assign status    = out_status_reg;
    assign count     = out_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(head_reg) < DEPTH)
        else $error("front position outside the store");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && dec_we) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted push did not grow the count");

    a_swap_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && dec_swap) |=> (state_reg == S_SWAP_A) ##1 (state_reg == S_SWAP_B))
        else $error("swap write-back sequence broken");

    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && !out_free) |=> (pend_valid_reg && $stable(pend_data_reg)))
        else $error("pending result lost while output stalled");
`endif

endmodule

`default_nettype wire

// File: bench/double_ended_queue_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_tb
    import deq_pkg::*;
();

    localparam int QUEUE_DEPTH = 1024;
    localparam int ITEM_TARGET = 1700;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400000;

    // Opcodes six and seven are spare: the block ignores them
    localparam opcode_t OP_SPARE_6 = 3'd6;
    localparam opcode_t OP_SPARE_7 = 3'd7;

    typedef struct packed {
        opcode_t              op;
        logic [DATA_W-1:0]    rd;
        status_t              st;
        logic [COUNT_W-1:0]   cnt;
    } deq_result_t;

    // Shadow deque: predicts each accepted beat, then holds the expected
    // result beats in order until the output side hands them in.
    class deque_scoreboard;
        logic [DATA_W-1:0]  slots [QUEUE_DEPTH];
        logic [INDEX_W-1:0] front;
        logic [COUNT_W-1:0] held;
        deq_result_t        awaited [$];
        int                 failures;
        int                 checked;
        int                 peak;
        int                 op_seen [8];
        int                 status_seen [4];

        function new();
            front    = '0;
            held     = '0;
            failures = 0;
            checked  = 0;
            peak     = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_item(opcode_t op, logic [DATA_W-1:0] d,
                                logic [INDEX_W-1:0] ia, logic [INDEX_W-1:0] ib);
            deq_result_t        r;
            logic [INDEX_W-1:0] sa;
            logic [INDEX_W-1:0] sb;
            logic [INDEX_W-1:0] tail;
            logic [DATA_W-1:0]  t;
            r.op = op;
            r.rd = '0;
            r.st = ST_OK;
            sa   = front + ia;
            sb   = front + ib;
            case (op)
                OP_PUSH_TAIL:
                    if (held >= QUEUE_DEPTH) r.st = ST_FULL;
                    else begin
                        tail = front + held[INDEX_W-1:0];
                        slots[tail] = d;
                        held++;
                    end
                OP_PUSH_FRONT:
                    if (held >= QUEUE_DEPTH) r.st = ST_FULL;
                    else begin
                        front = front - 1'b1;
                        slots[front] = d;
                        held++;
                    end
                OP_POP_TAIL:
                    if (held == 0) r.st = ST_EMPTY;
                    else begin
                        tail = front + held[INDEX_W-1:0] - 1'b1;
                        r.rd = slots[tail];
                        held--;
                    end
                OP_POP_FRONT:
                    if (held == 0) r.st = ST_EMPTY;
                    else begin
                        r.rd = slots[front];
                        front = front + 1'b1;
                        held--;
                    end
                OP_READ:
                    if (ia >= held) r.st = ST_RANGE;
                    else r.rd = slots[sa];
                OP_SWAP:
                    if (ia >= held || ib >= held) r.st = ST_RANGE;
                    else begin
                        t = slots[sa];
                        slots[sa] = slots[sb];
                        slots[sb] = t;
                    end
                default: ;
            endcase
            r.cnt = held;
            if (int'(held) > peak) peak = int'(held);
            op_seen[op]++;
            status_seen[r.st]++;
            awaited = {awaited, r};
        endfunction

        function void check_result(logic [DATA_W-1:0] rd, logic [STATUS_W-1:0] st,
                                   logic [COUNT_W-1:0] cnt);
            deq_result_t w;
            checked++;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display({"ERROR %0t: result beat with nothing expected: ",
                              "data %h status %0d count %0d"},
                             $realtime, rd, st, cnt);
                return;
            end
            w = awaited.pop_front();
            if (rd !== w.rd || st !== w.st || cnt !== w.cnt) begin
                failures++;
                if (failures <= 10)
                    $display({"ERROR %0t: op %0d expected data %h status %0d count %0d, ",
                              "got data %h status %0d count %0d"},
                             $realtime, w.op, w.rd, w.st, w.cnt, rd, st, cnt);
            end
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [OPCODE_W-1:0] opcode    = '0;
    logic [DATA_W-1:0]   data      = '0;
    logic [INDEX_W-1:0]  index_a   = '0;
    logic [INDEX_W-1:0]  index_b   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [DATA_W-1:0]   read_data;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;

    deque_scoreboard board;
    int              items_sent    = 0;
    int              cycle_count   = 0;
    int              tx_calm_left  = 0;
    bit              long_hold_req = 1'b0;

    double_ended_queue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .data      (data),
        .index_a   (index_a),
        .index_b   (index_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data),
        .status    (status),
        .count     (count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: bail out if the run hangs on a handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("double_ended_queue verification failed");
            $finish;
        end
    end

    // Idle length: mostly short, a few long, and now and then a calm
    // stretch of back-to-back beats
    function automatic int pick_gap();
        int roll;
        if (tx_calm_left > 0)
        begin
            tx_calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            tx_calm_left = $urandom_range(40, 150);
            return 0;
        end
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_stall();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Mostly a live logical index; sometimes any 10-bit value, which is
    // out of range when it is at or above the element count
    function automatic logic [INDEX_W-1:0] pick_index();
        if (board.held == 0 || $urandom_range(0, 7) == 0)
            return INDEX_W'($urandom_range(0, QUEUE_DEPTH - 1));
        return INDEX_W'($urandom_range(0, board.held - 1));
    endfunction

    // Offer one beat after an optional gap and hold it until accepted.
    // Valid stays high across back-to-back beats: lower it only for a gap.
    task automatic send_item(input opcode_t op, input logic [DATA_W-1:0] d,
                             input logic [INDEX_W-1:0] ia, input logic [INDEX_W-1:0] ib);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        data     <= d;
        index_a  <= ia;
        index_b  <= ib;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_item(op, d, ia, ib);
        if (op <= OP_SWAP) items_sent++;
    endtask

    // One random beat, opcode drawn by weight; spare opcodes slip in as noise
    task automatic random_item(input int push_w, input int pop_w,
                               input int read_w, input int swap_w);
        int                 roll;
        opcode_t            op;
        logic [INDEX_W-1:0] ia;
        logic [INDEX_W-1:0] ib;
        if ($urandom_range(0, 49) == 0)
            send_item($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7, $urandom,
                      INDEX_W'($urandom_range(0, QUEUE_DEPTH - 1)),
                      INDEX_W'($urandom_range(0, QUEUE_DEPTH - 1)));
        roll = $urandom_range(0, push_w + pop_w + read_w + swap_w - 1);
        if (roll < push_w)
            op = $urandom_range(0, 1) ? OP_PUSH_TAIL : OP_PUSH_FRONT;
        else if (roll < push_w + pop_w)
            op = $urandom_range(0, 1) ? OP_POP_TAIL : OP_POP_FRONT;
        else if (roll < push_w + pop_w + read_w)
            op = OP_READ;
        else
            op = OP_SWAP;
        ia = pick_index();
        ib = ($urandom_range(0, 9) == 0) ? ia : pick_index();
        send_item(op, $urandom, ia, ib);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) @(posedge clk);
    endtask

    // Result side: check every handshake, then pick the next ready level.
    // A long hold request from the sender holds ready low for a stall set by LONG_HOLD.
    initial
    begin : result_sink
        int stall_left;
        int calm_left;
        int roll;
        stall_left = 0;
        calm_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                board.check_result(read_data, status, count);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
                calm_left     = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                out_ready <= 1'b1;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                begin
                    calm_left = $urandom_range(50, 200);
                    out_ready <= 1'b1;
                end
                else if (roll < 22)
                begin
                    stall_left = pick_stall() - 1;
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        board = new();

        // Hold reset, then release it on an edge
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty deque: both pops flag empty, read and swap flag range
        send_item(OP_POP_TAIL, 32'hFFFF_FFFF, '0, '0);
        send_item(OP_POP_FRONT, 32'hFFFF_FFFF, '0, '0);
        send_item(OP_READ, '0, '0, '0);
        send_item(OP_SWAP, '0, '0, '0);

        // Push extremes; the front push wraps the head below slot zero
        send_item(OP_PUSH_TAIL, 32'hFFFF_FFFF, '0, '0);
        send_item(OP_PUSH_FRONT, 32'h0000_0000, 10'h3FF, 10'h3FF);
        send_item(OP_PUSH_TAIL, 32'hA5A5_A5A5, '0, '0);
        send_item(OP_PUSH_FRONT, 32'h5A5A_5A5A, '0, '0);

        // Reads in range, at the count, and at the top index
        send_item(OP_READ, '0, 10'd0, '0);
        send_item(OP_READ, '0, 10'd3, '0);
        send_item(OP_READ, '0, 10'd4, '0);
        send_item(OP_READ, '0, 10'h3FF, '0);

        // Swaps: plain, with itself, and with either index out of range
        send_item(OP_SWAP, '0, 10'd0, 10'd3);
        send_item(OP_SWAP, '0, 10'd2, 10'd2);
        send_item(OP_SWAP, '0, 10'd1, 10'h3FF);
        send_item(OP_SWAP, '0, 10'h3FF, 10'd0);
        send_item(OP_READ, '0, 10'd0, '0);

        // Spare opcodes change nothing
        send_item(OP_SPARE_6, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF);
        send_item(OP_SPARE_7, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF);

        // Drain from both ends until a pop flags empty again
        send_item(OP_POP_FRONT, '0, '0, '0);
        send_item(OP_POP_TAIL, '0, '0, '0);
        send_item(OP_POP_FRONT, '0, '0, '0);
        send_item(OP_POP_TAIL, '0, '0, '0);
        send_item(OP_POP_FRONT, '0, '0, '0);

        // Shallow mix: count wanders near empty
        while (items_sent < 270)
            random_item(30, 25, 25, 20);

        // Pause the sender until every result is back
        in_valid <= 1'b0;
        wait_drained();

        // Fill to the top while the receiver holds off, so the block backs up
        long_hold_req = 1'b1;
        while (board.held < QUEUE_DEPTH)
            random_item(92, 0, 4, 4);

        // Full deque: pushes refused, indices up to the last slot
        repeat (24) random_item(40, 0, 30, 30);

        // Pop-heavy mix for the rest of the run
        while (items_sent < ITEM_TARGET)
            random_item(20, 45, 20, 15);

        in_valid <= 1'b0;
        wait_drained();
        repeat (12) @(posedge clk);

        $display({"Covered %0d beats: push %0d/%0d, pop %0d/%0d, read %0d, swap %0d, ",
                  "spare %0d; peak fill %0d of %0d"},
                 items_sent + board.op_seen[6] + board.op_seen[7],
                 board.op_seen[0], board.op_seen[1], board.op_seen[2], board.op_seen[3],
                 board.op_seen[4], board.op_seen[5], board.op_seen[6] + board.op_seen[7],
                 board.peak, QUEUE_DEPTH);
        $display("Checked %0d results: ok %0d, full %0d, empty %0d, range %0d; mismatches %0d",
                 board.checked, board.status_seen[ST_OK], board.status_seen[ST_FULL],
                 board.status_seen[ST_EMPTY], board.status_seen[ST_RANGE], board.failures);

        if (board.failures == 0 && board.pending() == 0)
            $display("double_ended_queue verification clean");
        else
            $display("double_ended_queue verification failed");
        $finish;
    end

endmodule

// File: files.f
hdl/deq_pkg.sv
hdl/deq_store.sv
hdl/double_ended_queue.sv
bench/double_ended_queue_tb.sv
